// ===== hw/rtl/ibsu_pkg.sv =====
// ----------------------------------------------------------------------------
// ibsu_pkg
// Types and constants shared by the integer bit scan unit.
// ----------------------------------------------------------------------------
package ibsu_pkg;

	// largest operand width in bytes; the datapath is 64 bits wide
	localparam int unsigned MAX_BYTES = 8;
	localparam int unsigned DATA_W    = 64;
	localparam int unsigned NB_BYTES  = DATA_W / 8;
	localparam int unsigned EFF_BYTES = (MAX_BYTES < NB_BYTES) ? MAX_BYTES : NB_BYTES;
	localparam int unsigned BIDX_W    = $clog2(NB_BYTES);
	localparam int unsigned CNT_W     = $clog2(DATA_W + 1);

	// operation codes
	localparam logic [1:0] CMD_BSWAP = 2'd0;
	localparam logic [1:0] CMD_CLZ   = 2'd1;
	localparam logic [1:0] CMD_CTZ   = 2'd2;
	localparam logic [1:0] CMD_POPC  = 2'd3;

	typedef struct packed {
		logic [1:0]         cmd;
		logic [3:0]         width_bytes;
		logic [63:0]        operand;
		logic               use_zero_count;
		logic signed [31:0] zero_count;
	} ibsu_req_t;

	typedef struct packed {
		logic [63:0] result;
		logic        scan_of_zero;
	} ibsu_rsp_t;

endpackage

// ===== hw/rtl/integer_bit_scan_unit.sv =====
// ----------------------------------------------------------------------------
// integer_bit_scan_unit
// Byte swap, leading/trailing zero count and population count on a 64-bit
// operand masked to 1..8 bytes.
// ----------------------------------------------------------------------------
//
//  channel  | ports              | transfer
//  ---------+--------------------+------------------------------------------
//  request  | start, busy, req   | edge with start high and busy low
//  response | done, rsp          | edge ending the cycle that done is high
//
//  one item per cycle; busy is never raised
//  the request is registered into _s1 at its transfer edge and its
//    result then into _s2; done is driven from the _s2 valid bit, and the
//    response transfers at the edge that ends the cycle done is high
//  reset clears the valid bits only; payload registers are not reset
//  the receiver cannot stall: each response shows for exactly one cycle
//  the path between _s1 and _s2 is a byte priority encode, an 8-way byte
//    select, a bit encode and a 7-bit add then subtract; popcount is a sum
//    of eight 4-bit byte counts
//
module integer_bit_scan_unit
	import ibsu_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	output logic      busy,
	input  ibsu_req_t req,
	output logic      done,
	output ibsu_rsp_t rsp
);

	// stage 1: captured request
	ibsu_req_t req_s1;
	logic      valid_s1;

	// stage 2: result register
	ibsu_rsp_t rsp_s2;
	logic      valid_s2;

	// combinational datapath
	logic [3:0]          nb;         // clamped width in bytes
	logic [NB_BYTES-1:0] byte_en;    // bytes inside the width
	logic [63:0]         bits;       // masked operand
	logic [NB_BYTES-1:0] byte_nz;    // nonzero bytes
	logic [BIDX_W-1:0]   hi_byte;
	logic [BIDX_W-1:0]   lo_byte;
	logic [7:0]          hi_sel;
	logic [7:0]          lo_sel;
	logic [2:0]          hi_bit;
	logic [2:0]          lo_bit;
	logic [CNT_W-1:0]    bit_len;
	logic [CNT_W-1:0]    clz;
	logic [CNT_W-1:0]    ctz;
	logic [CNT_W-1:0]    popc;
	logic [63:0]         swapped;
	logic                is_zero;
	ibsu_rsp_t           rsp_d;

	// never stalls
	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			req_s1 <= req;
		end
		if (valid_s1) begin
			rsp_s2 <= rsp_d;
		end
	end

	// width clamp: zero means one byte, anything above the limit is the limit
	always_comb begin
		if (req_s1.width_bytes == 4'd0) begin
			nb = 4'd1;
		end else if (req_s1.width_bytes > 4'(EFF_BYTES)) begin
			nb = 4'(EFF_BYTES);
		end else begin
			nb = req_s1.width_bytes;
		end
	end

	// byte mask and per-byte summaries
	always_comb begin
		for (int i = 0; i < NB_BYTES; i++) begin
			byte_en[i]     = (4'(i) < nb);
			bits[i*8 +: 8] = byte_en[i] ? req_s1.operand[i*8 +: 8] : 8'h00;
			byte_nz[i]     = |bits[i*8 +: 8];
		end
		is_zero = ~|byte_nz;
	end

	// highest and lowest nonzero byte
	always_comb begin
		hi_byte = '0;
		lo_byte = '0;
		for (int i = 0; i < NB_BYTES; i++) begin
			if (byte_nz[i]) begin
				hi_byte = BIDX_W'(i);
			end
		end
		for (int i = NB_BYTES - 1; i >= 0; i--) begin
			if (byte_nz[i]) begin
				lo_byte = BIDX_W'(i);
			end
		end
	end

	// highest and lowest set bit inside the chosen bytes
	always_comb begin
		hi_sel = bits[hi_byte*8 +: 8];
		lo_sel = bits[lo_byte*8 +: 8];
		hi_bit = '0;
		lo_bit = '0;
		for (int i = 0; i < 8; i++) begin
			if (hi_sel[i]) begin
				hi_bit = 3'(i);
			end
		end
		for (int i = 7; i >= 0; i--) begin
			if (lo_sel[i]) begin
				lo_bit = 3'(i);
			end
		end
		bit_len = CNT_W'({hi_byte, hi_bit}) + CNT_W'(1);
		clz     = CNT_W'({nb, 3'b000}) - bit_len;
		ctz     = CNT_W'({lo_byte, lo_bit});
	end

	// population count: per-byte counts, then a sum of eight small values
	always_comb begin
		logic [3:0] byte_cnt [NB_BYTES];
		for (int i = 0; i < NB_BYTES; i++) begin
			byte_cnt[i] = '0;
			for (int j = 0; j < 8; j++) begin
				byte_cnt[i] = byte_cnt[i] + 4'(bits[i*8 + j]);
			end
		end
		popc = '0;
		for (int i = 0; i < NB_BYTES; i++) begin
			popc = popc + CNT_W'(byte_cnt[i]);
		end
	end

	// byte swap within the width; byte j of the result is byte nb-1-j
	always_comb begin
		logic [3:0] src;
		for (int j = 0; j < NB_BYTES; j++) begin
			src                = nb - 4'd1 - 4'(j);
			swapped[j*8 +: 8]  = (4'(j) < nb) ? bits[src[BIDX_W-1:0]*8 +: 8] : 8'h00;
		end
	end

	// result select
	always_comb begin
		rsp_d = '0;
		unique case (req_s1.cmd)
			CMD_BSWAP: begin
				rsp_d.result = swapped;
			end
			CMD_POPC: begin
				rsp_d.result = 64'(popc);
			end
			CMD_CLZ, CMD_CTZ: begin
				if (is_zero) begin
					if (req_s1.use_zero_count) begin
						rsp_d.result = {32'h0, req_s1.zero_count};
					end else begin
						rsp_d.scan_of_zero = 1'b1;
					end
				end else if (req_s1.cmd == CMD_CLZ) begin
					rsp_d.result = 64'(clz);
				end else begin
					rsp_d.result = 64'(ctz);
				end
			end
			default: begin
				rsp_d = '0;
			end
		endcase
	end

	assign done = valid_s2;
	assign rsp  = rsp_s2;

	// every request transfer gives a response, through _s1 and _s2
	a_req_to_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> ##1 done)
		else $error("response missing for accepted request");

	// no response without a valid request in _s1 before it
	a_rsp_from_req: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(valid_s1))
		else $error("response without request");

	// a flagged zero scan carries a zero result
	a_flag_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && rsp.scan_of_zero) |-> (rsp.result == 64'h0))
		else $error("zero scan flag with nonzero result");

	// the flag only comes from a scan command
	a_flag_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && (req_s1.cmd == CMD_BSWAP || req_s1.cmd == CMD_POPC))
		|=> !rsp.scan_of_zero)
		else $error("zero scan flag on swap or popcount");

endmodule
